// ===== rtl/blm_pkg.sv =====
// Shared widths, register codes and constants of the battery level monitor.
package blm_pkg;

  localparam int SAMPLE_W  = 13;
  localparam int TEMP_W    = 8;
  localparam int COMP_W    = 15;
  localparam int LEVEL_W   = 3;
  localparam int REG_W     = 16;
  localparam int NUM_REGS  = 4;
  localparam int REG_IDX_W = 2;
  localparam int OFF_W     = 12;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEVEL_THR1 = 2'd0,
    REG_LEVEL_THR2 = 2'd1,
    REG_LEVEL_THR3 = 2'd2,
    REG_ALARM_THR  = 2'd3
  } blm_reg_e;

  typedef logic [REG_W-1:0] reg_word_t;

  localparam reg_word_t REG_RESET [NUM_REGS] = '{16'd3000, 16'd3400, 16'd3800, 16'd3000};

  // Temperature compensation: 150 mV over 20 degrees, i.e. 7 mV per degree.
  localparam int VOLT_OFFSET_SPAN = 150;
  localparam int NOMINAL_TEMP_DEG = 20;
  localparam logic signed [TEMP_W-1:0] NOMINAL_TEMP = 8'sd20;
  localparam logic signed [TEMP_W-1:0] FAILED_TEMP  = -8'sd127;
  localparam logic signed [OFF_W-1:0]  OFF_PER_DEG  =
    OFF_W'(VOLT_OFFSET_SPAN / NOMINAL_TEMP_DEG);

  // Capacity level codes.
  localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

endpackage

// ===== rtl/blm_if.sv =====
// Valid/ready channel interfaces for the battery level monitor samples and results.
interface blm_in_if
  import blm_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_W-1:0]      voltage_sample;
  logic signed [TEMP_W-1:0] temperature;
  logic                     external_power;

  modport source (output valid, output voltage_sample, output temperature,
                  output external_power, input ready);
  modport sink   (input valid, input voltage_sample, input temperature,
                  input external_power, output ready);
endinterface

interface blm_out_if
  import blm_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] compensated_voltage;
  logic [LEVEL_W-1:0]       capacity_level;
  logic                     alarm_active;
  logic                     alarm_notify;

  modport source (output valid, output compensated_voltage, output capacity_level,
                  output alarm_active, output alarm_notify, input ready);
  modport sink   (input valid, input compensated_voltage, input capacity_level,
                  input alarm_active, input alarm_notify, output ready);
endinterface

// ===== rtl/battery_level_monitor_unit.sv =====
// Battery level monitor top level: sample history, averaging, compensation, level and alarm.
//
// Each accepted item writes its voltage sample into a ring of HISTORY_DEPTH entries
// (cleared at reset) and returns one result: the average of the ring entries taken in
// slot order up to the first zero entry, minus a temperature offset of 7 mV per degree
// below 20 C, bucketed into a level of 1 to 4 by three thresholds, plus the low
// battery alarm state and a notify flag. A temperature of -127 or below counts as
// unread and gives no offset; an empty history gives an average of 0. The block works
// on one item at a time: a small sequencer adds up the history one entry per cycle,
// then a shared restoring divider produces one quotient bit per cycle. The average is
// then compensated into a register and moved into the output register once that is
// free; an empty history skips the divider. The input goes ready again as soon as the
// result sits in the output register, so the next item can be accepted while the
// result waits to be taken. Thresholds are written through the plain configuration
// port (index 0..3: level 1, level 2, level 3, alarm); the user must write them only
// while idle, as the block itself does not enforce it.
module battery_level_monitor_unit
  import blm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  blm_in_if.sink               in_ch_i,
  blm_out_if.source            out_ch_o
);

  localparam int SLOT_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W     = SAMPLE_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_COMP,
    ST_EMIT
  } state_e;

  state_e                   state_q;
  logic [SAMPLE_W-1:0]      ring_q [HISTORY_DEPTH];
  logic [SLOT_W-1:0]        slot_q;
  reg_word_t                thr_q [NUM_REGS];
  logic [CNT_W-1:0]         scan_q;
  logic [SUM_W-1:0]         quo_q;
  logic [CNT_W-1:0]         rem_q;
  logic [DIV_CNT_W-1:0]     div_cnt_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic                     ext_q;
  logic signed [COMP_W-1:0] comp_q;
  logic                     alarm_q;
  logic                     out_valid_q;
  logic signed [COMP_W-1:0] out_comp_q;
  logic [LEVEL_W-1:0]       out_level_q;
  logic                     out_notify_q;

  logic in_acc;
  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_acc        = in_ch_i.valid && in_ch_i.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        thr_q[i] <= REG_RESET[i];
      end
    end else if (cfg_we_i) begin
      thr_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Sample history: write on accept, advance the write slot with wrap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      slot_q <= '0;
    end else if (in_acc) begin
      ring_q[slot_q] <= in_ch_i.voltage_sample;
      slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  // Scan read: one history entry per cycle; past the end reads as zero.
  logic                scan_end;
  logic [SAMPLE_W-1:0] scan_entry;
  assign scan_end   = (scan_q == CNT_W'(HISTORY_DEPTH));
  assign scan_entry = scan_end ? '0 : ring_q[scan_q[SLOT_W-1:0]];

  // Restoring divider step: total in quo_q, divisor is the entry count in scan_q.
  logic [CNT_W:0]   div_shift;
  logic [CNT_W:0]   div_diff;
  logic             div_ge;
  logic [CNT_W-1:0] rem_next;
  assign div_shift = {rem_q, quo_q[SUM_W-1]};
  assign div_diff  = div_shift - {1'b0, scan_q};
  assign div_ge    = (div_shift >= {1'b0, scan_q});
  assign rem_next  = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];

  // Temperature compensation; an unread sensor falls back to the nominal temperature.
  logic signed [TEMP_W-1:0] eff_temp;
  logic signed [TEMP_W:0]   temp_diff;
  logic signed [OFF_W-1:0]  diff_ext;
  logic signed [OFF_W-1:0]  temp_off;
  logic [SAMPLE_W-1:0]      avg;
  logic signed [COMP_W:0]   comp_full;
  assign eff_temp  = (temp_q <= FAILED_TEMP) ? NOMINAL_TEMP : temp_q;
  assign temp_diff = {NOMINAL_TEMP[TEMP_W-1], NOMINAL_TEMP}
                   - {eff_temp[TEMP_W-1], eff_temp};
  assign diff_ext  = {{(OFF_W - TEMP_W - 1){temp_diff[TEMP_W]}}, temp_diff};
  assign temp_off  = diff_ext * OFF_PER_DEG;
  assign avg       = quo_q[SAMPLE_W-1:0];
  assign comp_full = signed'({{(COMP_W + 1 - SAMPLE_W){1'b0}}, avg})
                   - {{(COMP_W + 1 - OFF_W){temp_off[OFF_W-1]}}, temp_off};

  // Level and alarm compares, signed against zero-extended thresholds.
  logic signed [REG_W:0] comp_ext;
  logic signed [REG_W:0] thr1_ext;
  logic signed [REG_W:0] thr2_ext;
  logic signed [REG_W:0] thr3_ext;
  logic signed [REG_W:0] alarm_ext;
  logic [LEVEL_W-1:0]    level;
  logic                  at_or_below;
  assign comp_ext  = {{(REG_W + 1 - COMP_W){comp_q[COMP_W-1]}}, comp_q};
  assign thr1_ext  = signed'({1'b0, thr_q[REG_LEVEL_THR1]});
  assign thr2_ext  = signed'({1'b0, thr_q[REG_LEVEL_THR2]});
  assign thr3_ext  = signed'({1'b0, thr_q[REG_LEVEL_THR3]});
  assign alarm_ext = signed'({1'b0, thr_q[REG_ALARM_THR]});
  assign at_or_below = (comp_ext <= alarm_ext);

  always_comb begin
    if (comp_ext > thr3_ext) begin
      level = LEVEL_4;
    end else if (comp_ext > thr2_ext) begin
      level = LEVEL_3;
    end else if (comp_ext > thr1_ext) begin
      level = LEVEL_2;
    end else begin
      level = LEVEL_1;
    end
  end

  // Sequencer: accept, sum, divide, compensate, emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      div_cnt_q   <= '0;
      alarm_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the valid once taken, unless a new result replaces it this cycle.
      if (out_valid_q && out_ch_o.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            temp_q  <= in_ch_i.temperature;
            ext_q   <= in_ch_i.external_power;
            scan_q  <= '0;
            quo_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_end || (scan_entry == '0)) begin
            div_cnt_q <= '0;
            rem_q     <= '0;
            // Empty history: skip the divider, the total is already zero.
            state_q   <= (scan_q == '0) ? ST_COMP : ST_DIV;
          end else begin
            quo_q  <= quo_q + SUM_W'(scan_entry);
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_DIV: begin
          quo_q     <= {quo_q[SUM_W-2:0], div_ge};
          rem_q     <= rem_next;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
            state_q <= ST_COMP;
          end
        end
        ST_COMP: begin
          comp_q  <= comp_full[COMP_W-1:0];
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold until the output register is free.
          if (!out_valid_q || out_ch_o.ready) begin
            out_comp_q  <= comp_q;
            out_level_q <= level;
            out_valid_q <= 1'b1;
            if (at_or_below && !ext_q) begin
              alarm_q      <= 1'b1;
              out_notify_q <= 1'b1;
            end else if (!at_or_below && alarm_q) begin
              alarm_q      <= 1'b0;
              out_notify_q <= 1'b1;
            end else begin
              out_notify_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The alarm state shown is the one after this item, so it tracks alarm_q.
  assign out_ch_o.valid               = out_valid_q;
  assign out_ch_o.compensated_voltage = out_comp_q;
  assign out_ch_o.capacity_level      = out_level_q;
  assign out_ch_o.alarm_active        = alarm_q;
  assign out_ch_o.alarm_notify        = out_notify_q;

endmodule

// ===== tb/sv/battery_level_monitor_unit_tb.sv =====
// Self-checking testbench for the battery level monitor: directed, threshold and random traffic.
module battery_level_monitor_unit_tb
  import blm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH  = 5;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  // No item may sit still longer than this; it is well above the longest hold-off below.
  localparam int STALL_LIMIT = 2000;
  // Cycles to let pass once the last reading is back.
  localparam int SETTLE_CYCLES = 40;
  localparam int MV_PER_DEG  = VOLT_OFFSET_SPAN / NOMINAL_TEMP_DEG;

  localparam logic signed [TEMP_W-1:0] TEMP_COLDEST = 8'sh80;
  localparam logic signed [TEMP_W-1:0] TEMP_HOTTEST = 8'sh7F;

  typedef struct {
    logic signed [COMP_W-1:0] comp;
    logic [LEVEL_W-1:0]       level;
    logic                     alarm;
    logic                     notify;
  } battery_reading_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  blm_reg_e   cfg_idx;
  reg_word_t  cfg_wdata;

  blm_in_if  in_ch ();
  blm_out_if out_ch ();

  battery_level_monitor_unit #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mirror of the monitor: sample history, write slot, alarm latch and the thresholds.
  logic [SAMPLE_W-1:0] hist_mv [HIST_DEPTH];
  int                  hist_slot;
  logic                alarm_latched;
  reg_word_t           thr [NUM_REGS];

  battery_reading_t expected_readings [$];
  int mismatches;

  // Idle knobs, in percent per cycle, and the long receiver hold-off in cycles.
  int send_idle_pct;
  int sink_stall_pct;
  int hold_len;

  // Store the sample, then average the history up to the first empty slot, subtract
  // the temperature offset, bucket into a level and update the alarm latch.
  function automatic battery_reading_t compute_reading(input logic [SAMPLE_W-1:0] mv,
                                                       input logic signed [TEMP_W-1:0] temp,
                                                       input logic ext_pwr);
    battery_reading_t r;
    int sum_mv, n_used, avg_mv, deg_c, comp_mv, k;
    bit seen_zero;
    hist_mv[hist_slot] = mv;
    hist_slot = (hist_slot + 1) % HIST_DEPTH;
    sum_mv = 0;
    n_used = 0;
    seen_zero = 1'b0;
    for (k = 0; k < HIST_DEPTH; k++) begin
      if (hist_mv[k] == '0) seen_zero = 1'b1;
      if (!seen_zero) begin
        sum_mv += hist_mv[k];
        n_used++;
      end
    end
    // An empty history averages to zero instead of dividing by zero.
    avg_mv = (n_used == 0) ? 0 : sum_mv / n_used;
    // A dead sensor reads as the nominal temperature, so no offset is applied.
    deg_c = temp;
    if (deg_c <= int'(FAILED_TEMP)) deg_c = NOMINAL_TEMP_DEG;
    comp_mv = avg_mv - MV_PER_DEG * (NOMINAL_TEMP_DEG - deg_c);

    r.notify = 1'b0;
    if (comp_mv <= int'(thr[REG_ALARM_THR]) && !ext_pwr) begin
      // Raise notifies every time, even with the alarm already on.
      alarm_latched = 1'b1;
      r.notify = 1'b1;
    end else if (comp_mv > int'(thr[REG_ALARM_THR]) && alarm_latched) begin
      alarm_latched = 1'b0;
      r.notify = 1'b1;
    end

    // Check from the top level down so unordered thresholds still give 1 to 4.
    if (comp_mv > int'(thr[REG_LEVEL_THR3]))      r.level = LEVEL_4;
    else if (comp_mv > int'(thr[REG_LEVEL_THR2])) r.level = LEVEL_3;
    else if (comp_mv > int'(thr[REG_LEVEL_THR1])) r.level = LEVEL_2;
    else                                          r.level = LEVEL_1;

    r.comp  = COMP_W'(comp_mv);
    r.alarm = alarm_latched;
    return r;
  endfunction

  // Offer one item, with random idle cycles ahead of it, and hold it until taken.
  // Leave valid high on return so a following item goes out back to back.
  task automatic send_sample(input logic [SAMPLE_W-1:0] mv,
                             input logic signed [TEMP_W-1:0] temp,
                             input logic ext_pwr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid          <= 1'b0;
      // Scramble the payload while idle; the block must not look at it.
      in_ch.voltage_sample <= SAMPLE_W'($urandom);
      in_ch.temperature    <= TEMP_W'($urandom);
      in_ch.external_power <= 1'($urandom);
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.voltage_sample <= mv;
    in_ch.temperature    <= temp;
    in_ch.external_power <= ext_pwr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_readings.push_back(compute_reading(mv, temp, ext_pwr));
  endtask

  // Draw a sample mostly from a window around the current thresholds, with
  // zeros, full-range values and dead-sensor temperatures mixed in.
  task automatic send_random_sample();
    int lo_mv, hi_mv, pick, deg;
    logic [SAMPLE_W-1:0] mv;
    logic signed [TEMP_W-1:0] temp;
    lo_mv = int'(thr[REG_LEVEL_THR1]);
    hi_mv = int'(thr[REG_LEVEL_THR3]);
    if (lo_mv > hi_mv) begin
      lo_mv = int'(thr[REG_LEVEL_THR3]);
      hi_mv = int'(thr[REG_LEVEL_THR1]);
    end
    lo_mv -= 600;
    hi_mv += 600;
    if (lo_mv < 1) lo_mv = 1;
    if (hi_mv > SAMPLE_MAX) hi_mv = SAMPLE_MAX;
    if (lo_mv > hi_mv) begin
      lo_mv = 1;
      hi_mv = SAMPLE_MAX;
    end

    pick = $urandom_range(99);
    if (pick < 4)       mv = '0;
    else if (pick < 22) mv = SAMPLE_W'($urandom_range(SAMPLE_MAX));
    else                mv = SAMPLE_W'($urandom_range(hi_mv, lo_mv));

    pick = $urandom_range(99);
    if (pick < 8) begin
      temp = pick[0] ? FAILED_TEMP : TEMP_COLDEST;
    end else if (pick < 50) begin
      deg = int'($urandom_range(55)) - 10;
      temp = TEMP_W'(deg);
    end else begin
      temp = TEMP_W'($urandom_range(255));
    end

    send_sample(mv, temp, $urandom_range(99) < 30);
  endtask

  task automatic run_random(input int n_items);
    repeat (n_items) send_random_sample();
  endtask

  // Drop valid and wait until every reading is back and the block has gone quiet.
  task automatic settle_monitor();
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive one register write; the caller lowers the write enable after the last one.
  task automatic put_reg(input blm_reg_e idx, input reg_word_t val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    thr[idx] = val;
  endtask

  // Write all four thresholds, only once the block is idle.
  task automatic reconfigure(input reg_word_t lv1, input reg_word_t lv2,
                             input reg_word_t lv3, input reg_word_t alarm_mv);
    settle_monitor();
    put_reg(REG_LEVEL_THR1, lv1);
    put_reg(REG_LEVEL_THR2, lv2);
    put_reg(REG_LEVEL_THR3, lv3);
    put_reg(REG_ALARM_THR,  alarm_mv);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hand-picked items at reset thresholds: empty history, dead sensor, repeated
  // raise, external power holding the alarm, clear, field extremes, middle zero.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_sample('0, NOMINAL_TEMP, 1'b0);              // empty history, raise
    send_sample('0, NOMINAL_TEMP, 1'b1);              // low on external power: hold
    send_sample(SAMPLE_W'(SAMPLE_MAX), TEMP_COLDEST, 1'b0); // raise again while on
    send_sample(SAMPLE_W'(SAMPLE_MAX), FAILED_TEMP, 1'b0);
    send_sample(SAMPLE_W'(4000), TEMP_HOTTEST, 1'b1); // slot 0 still empty
    send_sample(SAMPLE_W'(SAMPLE_MAX), -8'sd126, 1'b0); // slot 0 filled: clear
    send_sample(SAMPLE_W'(SAMPLE_MAX), TEMP_HOTTEST, 1'b1);
    send_sample(SAMPLE_W'(SAMPLE_MAX), TEMP_HOTTEST, 1'b0);
    send_sample(SAMPLE_W'(SAMPLE_MAX), TEMP_HOTTEST, 1'b0);
    send_sample(SAMPLE_W'(SAMPLE_MAX), TEMP_HOTTEST, 1'b0); // full ring: highest value
    repeat (5) send_sample(SAMPLE_W'(1), -8'sd126, 1'b0);   // lowest value
    send_sample('0, 8'sd0, 1'b0);                     // slot 0 zero again
    send_sample(SAMPLE_W'(7), -8'sd1, 1'b0);
    send_sample('0, NOMINAL_TEMP, 1'b0);              // zero in a middle slot
    send_sample(SAMPLE_W'(100), 8'sd19, 1'b1);
    send_sample(SAMPLE_W'(200), 8'sd21, 1'b0);
    send_sample(SAMPLE_W'(300), NOMINAL_TEMP, 1'b0);  // average stops at the zero
  endtask

  // Fill the ring with one value so the reading is exact, then move the thresholds
  // onto it to hit every comparison at equality.
  task automatic test_threshold_edges();
    int pivot_mv [3];
    int r;
    pivot_mv = '{3, SAMPLE_MAX, 0};
    pivot_mv[2] = $urandom_range(SAMPLE_MAX - 1, 3);
    for (r = 0; r < 3; r++) begin
      reconfigure(REG_W'(pivot_mv[r]), REG_W'(pivot_mv[r] + 1), REG_W'(pivot_mv[r] + 2),
                  REG_W'(pivot_mv[r]));
      repeat (5) send_sample(SAMPLE_W'(pivot_mv[r]), NOMINAL_TEMP, 1'b0); // level 1, raise
      reconfigure(REG_W'(pivot_mv[r] - 1), REG_W'(pivot_mv[r]), REG_W'(pivot_mv[r] + 1),
                  REG_W'(pivot_mv[r] - 1));
      send_sample(SAMPLE_W'(pivot_mv[r]), NOMINAL_TEMP, 1'b0);            // level 2, clear
      reconfigure(REG_W'(pivot_mv[r] - 2), REG_W'(pivot_mv[r] - 1), REG_W'(pivot_mv[r]),
                  REG_W'(pivot_mv[r]));
      send_sample(SAMPLE_W'(pivot_mv[r]), NOMINAL_TEMP, 1'b1);            // level 3, powered
      reconfigure(REG_W'(pivot_mv[r] - 3), REG_W'(pivot_mv[r] - 2), REG_W'(pivot_mv[r] - 1),
                  REG_W'(pivot_mv[r]));
      send_sample(SAMPLE_W'(pivot_mv[r]), NOMINAL_TEMP, 1'b0);            // level 4, raise
    end
  endtask

  // Extreme and odd threshold settings, each with a short burst of random items.
  task automatic test_config_extremes();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    reconfigure('0, '0, '0, '0);
    run_random(40);
    reconfigure('1, '1, '1, '1);
    run_random(40);
    // Level 1 threshold above level 3: buckets collapse but stay in 1 to 4.
    reconfigure(REG_W'(3800), REG_W'(3400), REG_W'(3000), REG_W'(3400));
    run_random(40);
    reconfigure(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), REG_W'($urandom));
    run_random(40);
  endtask

  // Long random traffic in four idle phases, each under its own thresholds.
  task automatic test_random_traffic();
    int t1;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    reconfigure(REG_RESET[REG_LEVEL_THR1], REG_RESET[REG_LEVEL_THR2],
                REG_RESET[REG_LEVEL_THR3], REG_RESET[REG_ALARM_THR]);
    run_random(340);

    t1 = $urandom_range(3400, 2200);
    reconfigure(REG_W'(t1), REG_W'(t1 + 300), REG_W'(t1 + 700),
                REG_W'($urandom_range(4000, 2000)));
    send_idle_pct = 53;
    run_random(340);

    reconfigure(REG_RESET[REG_LEVEL_THR1], REG_RESET[REG_LEVEL_THR2],
                REG_RESET[REG_LEVEL_THR3], REG_RESET[REG_ALARM_THR]);
    send_idle_pct  = 0;
    sink_stall_pct = 53;
    run_random(340);

    reconfigure(REG_W'($urandom_range(SAMPLE_MAX)), REG_W'($urandom_range(SAMPLE_MAX)),
                REG_W'($urandom_range(SAMPLE_MAX)), REG_W'($urandom_range(SAMPLE_MAX)));
    send_idle_pct  = 23;
    sink_stall_pct = 23;
    run_random(340);
  endtask

  // Hold the receiver off while items keep coming so the input backs up, then
  // pause the sender until everything is back, then repeat under random stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_len = 400;
    run_random(30);
    settle_monitor();
    sink_stall_pct = 53;
    hold_len = 250;
    run_random(30);
  endtask

  // Receiver: random ready, or a long hold-off counted here when one is requested.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Compare every taken reading with the oldest expectation, field by field.
  initial begin : reading_check
    battery_reading_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading comp %0d level %0d alarm %0b notify %0b",
                   $time, out_ch.compensated_voltage, out_ch.capacity_level,
                   out_ch.alarm_active, out_ch.alarm_notify);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (out_ch.compensated_voltage !== want.comp) begin
            $display("%0t: compensated_voltage expected %0d got %0d",
                     $time, want.comp, out_ch.compensated_voltage);
            mismatches++;
          end
          if (out_ch.capacity_level !== want.level) begin
            $display("%0t: capacity_level expected %0d got %0d",
                     $time, want.level, out_ch.capacity_level);
            mismatches++;
          end
          if (out_ch.alarm_active !== want.alarm) begin
            $display("%0t: alarm_active expected %0b got %0b",
                     $time, want.alarm, out_ch.alarm_active);
            mismatches++;
          end
          if (out_ch.alarm_notify !== want.notify) begin
            $display("%0t: alarm_notify expected %0b got %0b",
                     $time, want.notify, out_ch.alarm_notify);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when neither channel has moved an item for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    // Every input known from time zero; reset held low before the tests start.
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = REG_LEVEL_THR1;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.voltage_sample = '0;
    in_ch.temperature    = '0;
    in_ch.external_power = 1'b0;
    out_ch.ready         = 1'b0;
    send_idle_pct        = 0;
    sink_stall_pct       = 0;
    hold_len             = 0;
    mismatches           = 0;
    thr                  = REG_RESET;
    foreach (hist_mv[k]) hist_mv[k] = '0;
    hist_slot            = 0;
    alarm_latched        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_threshold_edges();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();

    // Wait out the last readings, then give the block time to show stray ones.
    settle_monitor();
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/blm_pkg.sv
rtl/blm_if.sv
rtl/battery_level_monitor_unit.sv
tb/sv/battery_level_monitor_unit_tb.sv
